// ===== rtl/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg: shared types and constants of the windowed sample averager
// Word layouts of both channels, phase codes, register indexes and the
// command and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int TEMP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 32;
  localparam int AVG_W   = 16;
  localparam int PHASE_W = 2;
  localparam int CFG_IDX_W = 2;

  // Phase codes as seen on the result channel
  localparam logic [PHASE_W-1:0] PH_SAMPLING = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SENDING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd2;

  localparam logic [CFG_W-1:0] RST_SAMPLING_WINDOW = 16'd5000;
  localparam logic [CFG_W-1:0] RST_IDLE_TIME       = 16'd5000;
  localparam logic [CFG_W-1:0] RST_SAMPLE_INTERVAL = 16'd1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     temperature_valid;
  } in_word_t;

  typedef struct packed {
    logic [PHASE_W-1:0]      phase;
    logic                    report_valid;
    logic signed [AVG_W-1:0] average;
    logic                    no_data;
    logic [COUNT_W-1:0]      sample_count;
  } out_word_t;

  typedef struct packed {
    logic tick;      // apply one input word to the state
    logic div_load;  // start the average division
    logic div_step;  // advance the divider one bit
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_need;  // the word at the input ends a window with samples
    logic div_last;  // divider is on its final bit
  } dp_status_t;

endpackage

// ===== rtl/windowed_sample_averager_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_sample_averager_unit: windowed temperature averager
// Each input word is one millisecond tick with a reading and a valid flag;
// each tick yields one result word with the phase, report and sample count.
//
// Channels: in_valid/in_stall/in_data carry ticks, out_valid/out_stall/
// out_data carry results; a word moves on a clock edge with valid high and
// stall low. cfg_valid/cfg_ready/cfg_index/cfg_data write the three window
// registers (0 sampling window, 1 idle time, 2 sample interval); cfg_ready
// is always high and other indexes are dropped. Write them only while idle.
//
// Latency: the result of a tick is on out_data in the cycle after the tick
// is taken. Throughput: one tick per cycle while the receiver does not
// stall, except the tick that closes a sampling window with samples: the
// sum is then divided by the count in a bit-serial divider, and the input
// is stalled for that time so the average is ready for the sending tick.
//
// Reset (rst_n low, synchronous): registers return to 5000/5000/1 ms, the
// phase to sampling, sums and counters to zero, no result pending.
// Receiver stall: the result word holds and the input stalls until it drains.
// ----------------------------------------------------------------------------
module windowed_sample_averager_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wsa_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wsa_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsa_pkg::CFG_W-1:0]     cfg_data
);
  import wsa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Registers take a write on any cycle
  assign cfg_ready = 1'b1;

  // Sequence ticks, the division and the result handshake
  wsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Window state, accumulation, divider and the result register
  wsa_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/wsa_div.sv =====
// ----------------------------------------------------------------------------
// wsa_div: bit-serial restoring divider
// Unsigned SUM_W by COUNT_W division, one quotient bit per step.
// ----------------------------------------------------------------------------
module wsa_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [wsa_pkg::SUM_W-1:0]   dividend,
  input  logic [wsa_pkg::COUNT_W-1:0] divisor,
  output logic                        last,
  output logic [wsa_pkg::SUM_W-1:0]   quotient
);
  import wsa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W-1:0] dvs_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sub[COUNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[COUNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= STEP_W'(SUM_W - 1);
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign last     = (cnt_r == '0);
  assign quotient = quo_nxt;

endmodule

// ===== rtl/wsa_datapath.sv =====
// ----------------------------------------------------------------------------
// wsa_datapath: averager state, configuration registers and result register
// Applies one tick per command, runs the average division and holds the
// outgoing word.
// ----------------------------------------------------------------------------
module wsa_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wsa_pkg::ctrl_cmd_t            cmd,
  output wsa_pkg::dp_status_t           status,
  input  wsa_pkg::in_word_t             in_data,
  input  logic                          cfg_we,
  input  logic [wsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsa_pkg::CFG_W-1:0]     cfg_data,
  output wsa_pkg::out_word_t            out_data
);
  import wsa_pkg::*;

  localparam int EXT_W = SUM_W + 2;
  localparam logic signed [EXT_W-1:0] SUM_MAX = EXT_W'(64'sd2147483647);
  localparam logic signed [EXT_W-1:0] SUM_MIN = EXT_W'(-64'sd2147483648);
  localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(32767);
  localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(32768);

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    sat_inc = (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  logic [CFG_W-1:0]   win_r, idle_r, intv_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        since_r, since_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic signed [AVG_W-1:0] held_r, held_nxt;
  logic               empty_r, empty_nxt;
  logic               neg_r;
  out_word_t          out_r, out_nxt;

  logic [15:0]        elapsed_inc, since_inc;
  logic signed [EXT_W-1:0] sample_ext, sum_add;
  logic               div_need;
  logic [SUM_W-1:0]   div_mag;
  logic               div_last;
  logic [SUM_W-1:0]   div_quo;
  logic signed [AVG_W-1:0] div_avg;

  // Reading as a SAMPLE_WIDTH-bit two's complement value; a SAMPLE_WIDTH above TEMP_W zero-extends the reading
  if (SAMPLE_WIDTH <= TEMP_W) begin : g_narrow
    logic signed [SAMPLE_WIDTH-1:0] raw;
    assign raw        = in_data.temperature[SAMPLE_WIDTH-1:0];
    assign sample_ext = EXT_W'(raw);
  end else begin : g_wide
    assign sample_ext = signed'({{(EXT_W-TEMP_W){1'b0}}, in_data.temperature});
  end

  assign sum_add = EXT_W'(sum_r) + sample_ext;

  always_comb begin
    elapsed_inc = sat_inc(elapsed_r);
    since_inc   = sat_inc(since_r);
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_inc;
    since_nxt   = since_inc;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    held_nxt    = held_r;
    empty_nxt   = empty_r;
    div_need    = 1'b0;
    out_nxt     = '0;

    case (phase_r)
      PH_SENDING: begin
        out_nxt.report_valid = 1'b1;
        out_nxt.average      = held_r;
        out_nxt.no_data      = empty_r;
        phase_nxt            = PH_IDLE;
        elapsed_nxt          = '0;
      end
      PH_IDLE: begin
        if (elapsed_inc >= idle_r) begin
          sum_nxt     = '0;
          count_nxt   = '0;
          held_nxt    = '0;
          phase_nxt   = PH_SAMPLING;
          elapsed_nxt = '0;
        end
      end
      PH_SAMPLING: begin
        if (since_inc >= intv_r) begin
          if (in_data.temperature_valid) begin
            if (sum_add > SUM_MAX) begin
              sum_nxt = SUM_MAX[SUM_W-1:0];
            end else if (sum_add < SUM_MIN) begin
              sum_nxt = SUM_MIN[SUM_W-1:0];
            end else begin
              sum_nxt = sum_add[SUM_W-1:0];
            end
            count_nxt = sat_inc(count_r);
          end
          since_nxt = '0;
        end
        if (elapsed_inc >= win_r) begin
          if (count_nxt != '0) begin
            div_need  = 1'b1;
            empty_nxt = 1'b0;
          end else begin
            held_nxt  = '0;
            empty_nxt = 1'b1;
          end
          phase_nxt   = PH_SENDING;
          elapsed_nxt = '0;
        end
      end
      default: begin
        phase_nxt   = PH_SAMPLING;
        elapsed_nxt = '0;
      end
    endcase

    out_nxt.phase        = phase_nxt;
    out_nxt.sample_count = count_nxt;
  end

  assign div_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

  wsa_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (div_mag),
    .divisor  (count_nxt),
    .last     (div_last),
    .quotient (div_quo)
  );

  // Restore sign and clamp to the 16-bit range
  always_comb begin
    if (neg_r) begin
      div_avg = (div_quo > NEG_LIMIT) ? -16'sd32768 : -signed'(div_quo[AVG_W-1:0]);
    end else begin
      div_avg = (div_quo > POS_LIMIT) ? 16'sd32767 : signed'(div_quo[AVG_W-1:0]);
    end
  end

  assign status.div_need = div_need;
  assign status.div_last = div_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= RST_SAMPLING_WINDOW;
      idle_r    <= RST_IDLE_TIME;
      intv_r    <= RST_SAMPLE_INTERVAL;
      phase_r   <= PH_SAMPLING;
      elapsed_r <= '0;
      since_r   <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      held_r    <= '0;
      empty_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLING_WINDOW: win_r  <= cfg_data;
          CFG_IDLE_TIME:       idle_r <= cfg_data;
          CFG_SAMPLE_INTERVAL: intv_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        phase_r   <= phase_nxt;
        elapsed_r <= elapsed_nxt;
        since_r   <= since_nxt;
        sum_r     <= sum_nxt;
        count_r   <= count_nxt;
        held_r    <= held_nxt;
        empty_r   <= empty_nxt;
      end else if (cmd.div_step && div_last) begin
        held_r <= div_avg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= sum_nxt[SUM_W-1];
    end
    if (cmd.tick) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/wsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsa_ctrl: sequencing of ticks and divisions
// Decides when a word is taken, drives the divider and the result valid.
// ----------------------------------------------------------------------------
module wsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wsa_pkg::dp_status_t status,
  output wsa_pkg::ctrl_cmd_t  cmd
);
  import wsa_pkg::*;

  typedef enum logic {
    S_READY,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   busy;
  logic   accept;

  assign busy   = (state_r != S_READY) || (out_valid_r && out_stall);
  assign accept = in_valid && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_READY: if (accept && status.div_need) state_nxt = S_DIV;
      S_DIV:   if (status.div_last)           state_nxt = S_READY;
      default: state_nxt = S_READY;
    endcase
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.tick     = accept;
  assign cmd.div_load = accept && status.div_need;
  assign cmd.div_step = (state_r == S_DIV);
  assign in_stall     = busy;
  assign out_valid    = out_valid_r;

endmodule
